// File: design/m3inv_pkg.sv
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants for the 3x3 matrix inverse core: default entry and result
// widths.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int IN_WIDTH_DEF  = 16;
	localparam int OUT_WIDTH_DEF = 32;
	localparam int MAT_ENTRIES   = 9;

endpackage

// File: design/matrix3x3_inverse_core.sv
// ----------------------------------------------------------------------------
// matrix3x3_inverse_core
// Pipelined 3x3 matrix inverse by adjugate over determinant, fixed point.
// ----------------------------------------------------------------------------
// One matrix enters per clock and one result leaves per clock while
// out_ready holds. Seven front stages form the products, the cyclic
// cofactors, the determinant down column 0, the magnitudes and the
// overflow check; then nine parallel restoring dividers produce one
// quotient bit per stage over OUT_WIDTH + 1 stages; one final stage
// applies sign, saturation and the singular case. Every stage has its own
// valid bit and moves whenever the stage after it has room, so bubbles
// close up and the input stays ready until every stage holds an item,
// also while a finished result is waiting. Entries are signed
// Q(IN_WIDTH/2).(IN_WIDTH/2); inverse entries are signed Q(OUT_WIDTH/2).(OUT_WIDTH/2),
// rounded toward zero and clipped with the saturated flag; the determinant
// is exact. A zero determinant gives zero entries and raises singular.
// ----------------------------------------------------------------------------
module matrix3x3_inverse_core #(
	parameter int IN_WIDTH  = m3inv_pkg::IN_WIDTH_DEF,
	parameter int OUT_WIDTH = m3inv_pkg::OUT_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [IN_WIDTH-1:0]  a00,
	input  logic signed [IN_WIDTH-1:0]  a01,
	input  logic signed [IN_WIDTH-1:0]  a02,
	input  logic signed [IN_WIDTH-1:0]  a10,
	input  logic signed [IN_WIDTH-1:0]  a11,
	input  logic signed [IN_WIDTH-1:0]  a12,
	input  logic signed [IN_WIDTH-1:0]  a20,
	input  logic signed [IN_WIDTH-1:0]  a21,
	input  logic signed [IN_WIDTH-1:0]  a22,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic signed [OUT_WIDTH-1:0] b00,
	output logic signed [OUT_WIDTH-1:0] b01,
	output logic signed [OUT_WIDTH-1:0] b02,
	output logic signed [OUT_WIDTH-1:0] b10,
	output logic signed [OUT_WIDTH-1:0] b11,
	output logic signed [OUT_WIDTH-1:0] b12,
	output logic signed [OUT_WIDTH-1:0] b20,
	output logic signed [OUT_WIDTH-1:0] b21,
	output logic signed [OUT_WIDTH-1:0] b22,
	output logic signed [3*IN_WIDTH:0]  determinant,
	output logic                        singular,
	output logic                        saturated
);

	localparam int NE   = m3inv_pkg::MAT_ENTRIES;
	localparam int IW   = IN_WIDTH;
	localparam int OW   = OUT_WIDTH;
	localparam int PW   = 2 * IW;
	localparam int CW   = 2 * IW + 1;
	localparam int DW   = 3 * IW + 1;
	localparam int MW   = 2 * IW;
	localparam int DMW  = 3 * IW;
	localparam int SH   = IW / 2 + OW / 2;
	localparam int QW   = OW + 1;
	localparam int NW   = MW + SH + QW;
	localparam int CMPW = (MW + SH > DMW) ? (MW + SH) : DMW;
	localparam int NS   = QW + 8;
	localparam int SF   = NS - 1;

	typedef struct packed {
		logic [NE-1:0][DMW-1:0] rem;
		logic [NE-1:0][QW-1:0]  nlo;
		logic [NE-1:0][QW-1:0]  quo;
		logic [NE-1:0]          ovf;
		logic [NE-1:0]          neg;
		logic [DMW-1:0]         dabs;
		logic signed [DW-1:0]   det;
		logic                   sing;
	} div_t;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;

	logic signed [IW-1:0] a_s1   [3][3];
	logic signed [PW-1:0] pa_s2  [3][3];
	logic signed [PW-1:0] pb_s2  [3][3];
	logic signed [IW-1:0] c0_s2  [3];
	logic signed [CW-1:0] cof_s3 [3][3];
	logic signed [IW-1:0] c0_s3  [3];
	logic signed [DW-1:0] t_s4   [3];
	logic signed [CW-1:0] cof_s4 [3][3];
	logic signed [DW-1:0] det_s5;
	logic signed [CW-1:0] cof_s5 [3][3];
	logic [DMW-1:0]       dabs_s6;
	logic [MW-1:0]        cabs_s6 [NE];
	logic [NE-1:0]        neg_s6;
	logic signed [DW-1:0] det_s6;
	logic                 sing_s6;
	div_t                 dv_s [QW+1];
	div_t                 dv_nx [QW+1];
	logic signed [OW-1:0] b_sf [NE];
	logic signed [DW-1:0] det_sf;
	logic                 sing_sf;
	logic                 sat_sf;
	logic signed [OW-1:0] b_nx [NE];
	logic [NE-1:0]        sat_nx;

	// handshake: each stage advances when it is empty or its successor moves
	always_comb begin
		en[SF] = !vld_q[SF] || out_ready;
		for (int i = SF - 1; i >= 0; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_q[SF];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			a_s1[0][0] <= a00; a_s1[0][1] <= a01; a_s1[0][2] <= a02;
			a_s1[1][0] <= a10; a_s1[1][1] <= a11; a_s1[1][2] <= a12;
			a_s1[2][0] <= a20; a_s1[2][1] <= a21; a_s1[2][2] <= a22;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int R1 = (r + 1) % 3;
			localparam int R2 = (r + 2) % 3;
			localparam int C1 = (c + 1) % 3;
			localparam int C2 = (c + 2) % 3;
			always_ff @(posedge clk) begin
				if (en[1]) begin
					pa_s2[r][c] <= PW'(a_s1[R1][C1]) * PW'(a_s1[R2][C2]);
					pb_s2[r][c] <= PW'(a_s1[R1][C2]) * PW'(a_s1[R2][C1]);
				end
				if (en[2]) begin
					cof_s3[r][c] <= CW'(pa_s2[r][c]) - CW'(pb_s2[r][c]);
				end
				if (en[3]) begin
					cof_s4[r][c] <= cof_s3[r][c];
				end
				if (en[4]) begin
					cof_s5[r][c] <= cof_s4[r][c];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[1]) begin
				c0_s2[r] <= a_s1[r][0];
			end
			if (en[2]) begin
				c0_s3[r] <= c0_s2[r];
			end
			if (en[3]) begin
				t_s4[r] <= DW'(c0_s3[r]) * DW'(cof_s3[r][0]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			det_s5 <= t_s4[0] + t_s4[1] + t_s4[2];
		end
		if (en[5]) begin
			dabs_s6 <= det_s5[DW-1] ? DMW'(-det_s5) : DMW'(det_s5);
			det_s6  <= det_s5;
			sing_s6 <= (det_s5 == '0);
		end
	end

	// entry (r,c) of the inverse takes the transposed cofactor C(c,r)
	for (genvar e = 0; e < NE; e++) begin : g_ent
		localparam int ER = e / 3;
		localparam int EC = e % 3;
		logic [NW-1:0]   nx;
		logic [CMPW-1:0] hx;
		assign nx = {{QW{1'b0}}, cabs_s6[e], {SH{1'b0}}};
		assign hx = CMPW'(nx[NW-1:QW]);

		always_ff @(posedge clk) begin
			if (en[5]) begin
				cabs_s6[e] <= cof_s5[EC][ER][CW-1] ? MW'(-cof_s5[EC][ER])
				                                   : MW'(cof_s5[EC][ER]);
				neg_s6[e]  <= cof_s5[EC][ER][CW-1] ^ det_s5[DW-1];
			end
		end

		always_comb begin
			dv_nx[0].rem[e] = hx[DMW-1:0];
			dv_nx[0].nlo[e] = nx[QW-1:0];
			dv_nx[0].quo[e] = '0;
			dv_nx[0].ovf[e] = (hx >= CMPW'(dabs_s6));
			dv_nx[0].neg[e] = neg_s6[e];
		end
	end

	always_comb begin
		dv_nx[0].dabs = dabs_s6;
		dv_nx[0].det  = det_s6;
		dv_nx[0].sing = sing_s6;
	end

	// one restoring quotient bit per stage for all nine entries
	for (genvar k = 1; k <= QW; k++) begin : g_div
		always_comb begin
			logic [DMW:0] trial;
			dv_nx[k] = dv_s[k-1];
			for (int e = 0; e < NE; e++) begin
				trial = {dv_s[k-1].rem[e], dv_s[k-1].nlo[e][QW-1]};
				if (trial >= {1'b0, dv_s[k-1].dabs}) begin
					dv_nx[k].rem[e] = DMW'(trial - {1'b0, dv_s[k-1].dabs});
					dv_nx[k].quo[e] = {dv_s[k-1].quo[e][QW-2:0], 1'b1};
				end else begin
					dv_nx[k].rem[e] = trial[DMW-1:0];
					dv_nx[k].quo[e] = {dv_s[k-1].quo[e][QW-2:0], 1'b0};
				end
				dv_nx[k].nlo[e] = {dv_s[k-1].nlo[e][QW-2:0], 1'b0};
			end
		end
	end

	for (genvar k = 0; k <= QW; k++) begin : g_dreg
		always_ff @(posedge clk) begin
			if (en[k+6]) begin
				dv_s[k] <= dv_nx[k];
			end
		end
	end

	always_comb begin
		logic [QW-1:0] lim_pos;
		logic [QW-1:0] lim_neg;
		logic [QW-1:0] qv;
		logic [QW-1:0] qn;
		lim_pos = {2'b00, {(OW-1){1'b1}}};
		lim_neg = {2'b01, {(OW-1){1'b0}}};
		for (int e = 0; e < NE; e++) begin
			qv = dv_s[QW].quo[e];
			qn = -qv;
			sat_nx[e] = 1'b0;
			b_nx[e]   = '0;
			if (!dv_s[QW].sing) begin
				if (dv_s[QW].ovf[e] || (!dv_s[QW].neg[e] && qv > lim_pos) ||
				    (dv_s[QW].neg[e] && qv > lim_neg)) begin
					sat_nx[e] = 1'b1;
					b_nx[e]   = dv_s[QW].neg[e] ? {1'b1, {(OW-1){1'b0}}}
					                            : {1'b0, {(OW-1){1'b1}}};
				end else begin
					b_nx[e] = dv_s[QW].neg[e] ? qn[OW-1:0] : qv[OW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[SF]) begin
			for (int e = 0; e < NE; e++) begin
				b_sf[e] <= b_nx[e];
			end
			det_sf  <= dv_s[QW].det;
			sing_sf <= dv_s[QW].sing;
			sat_sf  <= |sat_nx;
		end
	end

	assign b00         = b_sf[0];
	assign b01         = b_sf[1];
	assign b02         = b_sf[2];
	assign b10         = b_sf[3];
	assign b11         = b_sf[4];
	assign b12         = b_sf[5];
	assign b20         = b_sf[6];
	assign b21         = b_sf[7];
	assign b22         = b_sf[8];
	assign determinant = det_sf;
	assign singular    = sing_sf;
	assign saturated   = sat_sf;

	a_sing_det : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> determinant == '0 && !saturated)
		else $error("singular result with nonzero determinant or saturation");

	a_det_sing : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !singular |-> determinant != '0)
		else $error("zero determinant not flagged singular");

	a_sing_zero : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && singular |-> b00 == '0 && b11 == '0 && b22 == '0)
		else $error("singular result with nonzero entries");

	a_full_stall : assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_q)
		else $error("input stalled while pipeline has a bubble");

endmodule
